>>> hw/rtl/b122_pkg.sv
`default_nettype none

package b122_pkg;

   localparam int MAX_CODES   = 4;
   localparam int COUNT_W     = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       run_end;
      logic       message_end;
   } rsp_type;

   // one request's worth of encoded bytes, oldest in code[0]
   typedef struct packed {
      logic [MAX_CODES-1:0][7:0] code;
      logic [COUNT_W-1:0]        count;
      logic                      last_flag;
   } desc_type;

endpackage

`default_nettype wire

>>> hw/rtl/b122_front.sv
`default_nettype none

module b122_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire b122_pkg::req_type req_data,
   output logic                   desc_push,
   output b122_pkg::desc_type     desc_data,
   input  wire logic              desc_full
);

   localparam logic [2:0] FLUSH_SSS = 3'd7;
   localparam logic [6:0] ILLEGAL_TABLE [8] = '{7'd0, 7'd10, 7'd13, 7'd34, 7'd38, 7'd92,
                                                7'd0, 7'd0};

   logic [5:0] lbits_ff, lbits_in;
   logic [2:0] lcount_ff, lcount_in;
   logic       pend_ff, pend_in;
   logic [2:0] pidx_ff, pidx_in;

   logic        accept;
   logic [13:0] acc;
   logic        two_chunks;
   logic [2:0]  new_count;
   logic [5:0]  new_bits;
   logic [6:0]  chunk [3];
   logic [2:0]  chunk_ok;
   logic        pend_w;
   logic [2:0]  pidx_w;
   logic [2:0]  n_w;
   logic [b122_pkg::MAX_CODES-1:0][7:0] codes_w;
   logic        hit_w;
   logic [2:0]  slot_w;

   function automatic logic [5:0] low_mask(input logic [2:0] n);
      logic [6:0] m;
      m = (7'd1 << n) - 7'd1;
      return m[5:0];
   endfunction

   function automatic logic [7:0] pair_first(input logic [2:0] sss, input logic [6:0] partner);
      return {3'b110, sss, 1'b1, partner[6]};
   endfunction

   function automatic logic [7:0] pair_second(input logic [6:0] partner);
      return {2'b10, partner[5:0]};
   endfunction

   assign accept = push && !full;
   assign full   = desc_full;

   always_comb begin
      acc        = {lbits_ff & low_mask(lcount_ff), req_data.data_byte};
      two_chunks = (lcount_ff == 3'd6);
      new_count  = two_chunks ? 3'd0 : lcount_ff + 3'd1;
      new_bits   = req_data.data_byte[5:0] & low_mask(new_count);
      chunk[0]   = 7'(acc >> (lcount_ff + 3'd1));
      chunk[1]   = acc[6:0];
      chunk[2]   = 7'({1'b0, new_bits} << (3'd7 - new_count));
      chunk_ok   = {req_data.final_byte && (new_count != 3'd0), two_chunks, 1'b1};

      pend_w  = pend_ff;
      pidx_w  = pidx_ff;
      n_w     = '0;
      codes_w = '0;
      hit_w   = 1'b0;
      slot_w  = '0;
      for (int i = 0; i < 3; i++) begin
         if (chunk_ok[i]) begin
            if (pend_w) begin
               codes_w[n_w[1:0]] = pair_first(pidx_w, chunk[i]);
               n_w = n_w + 3'd1;
               codes_w[n_w[1:0]] = pair_second(chunk[i]);
               n_w = n_w + 3'd1;
               pend_w = 1'b0;
               pidx_w = '0;
            end else begin
               hit_w  = 1'b0;
               slot_w = '0;
               for (int k = 0; k < 6; k++) begin
                  if (!hit_w && chunk[i] == ILLEGAL_TABLE[k]) begin
                     hit_w  = 1'b1;
                     slot_w = 3'(k);
                  end
               end
               if (hit_w) begin
                  pend_w = 1'b1;
                  pidx_w = slot_w;
               end else begin
                  codes_w[n_w[1:0]] = {1'b0, chunk[i]};
                  n_w = n_w + 3'd1;
               end
            end
         end
      end
      if (req_data.final_byte && pend_w) begin
         codes_w[n_w[1:0]] = pair_first(FLUSH_SSS, ILLEGAL_TABLE[pidx_w]);
         n_w = n_w + 3'd1;
         codes_w[n_w[1:0]] = pair_second(ILLEGAL_TABLE[pidx_w]);
         n_w = n_w + 3'd1;
      end
   end

   always_comb begin
      lbits_in  = lbits_ff;
      lcount_in = lcount_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      if (accept) begin
         if (req_data.final_byte) begin
            lbits_in  = '0;
            lcount_in = '0;
            pend_in   = 1'b0;
            pidx_in   = '0;
         end else begin
            lbits_in  = new_bits;
            lcount_in = new_count;
            pend_in   = pend_w;
            pidx_in   = pidx_w;
         end
      end
   end

   assign desc_push           = accept && (n_w != 3'd0);
   assign desc_data.code      = codes_w;
   assign desc_data.count     = n_w;
   assign desc_data.last_flag = req_data.final_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         lbits_ff  <= '0;
         lcount_ff <= '0;
         pend_ff   <= 1'b0;
         pidx_ff   <= '0;
      end else begin
         lbits_ff  <= lbits_in;
         lcount_ff <= lcount_in;
         pend_ff   <= pend_in;
         pidx_ff   <= pidx_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      lcount_ff <= 3'd6)
      else $error("leftover count out of range");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.final_byte |=> lcount_ff == 3'd0 && !pend_ff)
      else $error("state not cleared after final request");

   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.final_byte |-> desc_push)
      else $error("final request produced no output");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/b122_fifo.sv
`default_nettype none

module b122_fifo #(
   parameter int Depth = b122_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire b122_pkg::desc_type wr_data,
   output logic                    full,
   input  wire logic               rd_en,
   output b122_pkg::desc_type      rd_data,
   output logic                    empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(Depth);

   b122_pkg::desc_type mem_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full    = (count_ff == DEPTH_C);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/b122_back.sv
`default_nettype none

module b122_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire b122_pkg::desc_type desc_data,
   input  wire logic               desc_empty,
   output logic                    desc_pop,
   output logic                    empty,
   input  wire logic               pop,
   output b122_pkg::rsp_type       rsp_data
);

   localparam int IW = $clog2(b122_pkg::MAX_CODES);

   b122_pkg::desc_type cur_ff, cur_in;
   logic               valid_ff, valid_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               last, take, advance;

   assign last    = (b122_pkg::COUNT_W'(idx_ff) == cur_ff.count - b122_pkg::COUNT_W'(1));
   assign take    = pop && valid_ff;
   assign advance = !valid_ff || (take && last);
   assign desc_pop = advance && !desc_empty;

   assign empty                = !valid_ff;
   assign rsp_data.code_byte   = cur_ff.code[idx_ff];
   assign rsp_data.run_end     = last;
   assign rsp_data.message_end = last && cur_ff.last_flag;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (advance) begin
         cur_in   = desc_data;
         valid_in = !desc_empty;
         idx_in   = '0;
      end else if (take) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> cur_ff.count != '0 && b122_pkg::COUNT_W'(idx_ff) < cur_ff.count)
      else $error("output index beyond request's code count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/base122_stream_encoder_core.sv
`default_nettype none

// channel   direction  accept condition      payload
// req       in         push && !full         req_data (data_byte, final_byte)
// rsp       out        pop && !empty         rsp_data (code_byte, run_end, message_end)
//
// One request is accepted per cycle while the queue has room; the front
// encodes all of its 0..4 output bytes in that cycle.
// The back end drains one byte per cycle while rsp is popped.
// Reset is synchronous and clears the bit buffer, the queue and the output stage.
// A stalled rsp side backs up through the queue to full without losing data.

module base122_stream_encoder_core #(
   parameter int QueueDepth = b122_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire b122_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output b122_pkg::rsp_type      rsp_data
);

   b122_pkg::desc_type front_desc, queue_desc;
   logic front_push, queue_full, queue_empty, back_pop;

   b122_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .desc_push (front_push),
      .desc_data (front_desc),
      .desc_full (queue_full)
   );

   b122_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_desc),
      .full    (queue_full),
      .rd_en   (back_pop),
      .rd_data (queue_desc),
      .empty   (queue_empty)
   );

   b122_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_data  (queue_desc),
      .desc_empty (queue_empty),
      .desc_pop   (back_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
